FILE: hw/rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpening filter: pixel
// and result items, configuration bundle, column item between the line
// store stage and the window stage, and register indexes.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // Field widths fixed by the item formats
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int FW_W     = 12;   // frame_width register
    localparam int FH_W     = 16;   // frame_height register
    localparam int COL_W    = 12;   // column counter, holds up to frame_width - 1
    localparam int ROW_W    = 16;
    localparam int OCOL_W   = 11;   // reported column index
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ALPHA_ENABLE = 2'd2
    } reg_idx_t;

    // Lane 0 blue, 1 green, 2 red, 3 alpha
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_alpha;
    } pixel_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_alpha;
        logic [ROW_W-1:0]  out_row;
        logic [OCOL_W-1:0] out_col;
        logic              last_of_run;
        logic              frame_done;
    } result_item_t;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
        logic            alpha_enable;
    } cfg_t;

    // One new window column with the position of the pixel that brought it
    typedef struct packed {
        pixel_t           top;
        pixel_t           mid;
        pixel_t           cur;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_end;
        logic             last_row;
    } col_item_t;

endpackage

FILE: hw/rtl/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 Laplacian sharpening filter (centre 9, neighbours -1, replicate
// padding, clamp to 0..255) on a raster-order four-channel pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on pixel_valid/pixel_ready; sharpened
//   results leave on result_valid/result_ready, each tagged with its row and
//   column. A result is emitted once its lower-right neighbour (or the
//   border) is known, so row-end pixels give up to two results and last-row pixels
//   up to four; last_of_run marks the final result of a pixel, frame_done
//   the bottom-right pixel of the frame.
//   The first result of a pixel passes the line store read at the
//   accepting edge, then the window update, then the output register.
//   Throughput: one pixel per cycle while results are taken; a pixel that
//   owes k results (k >= 2) keeps the window busy until its last result
//   is emitted, so the input stalls meanwhile.
//   Configure frame size and alpha through the APB port while idle.
//   Reset clears the position counters, window and handshakes and loads
//   640x480, alpha off. Line stores are not cleared: each entry is written
//   in the first row before its read value is used. When result_ready is low, the output
//   register holds; the window and line store stages keep one pixel each,
//   then pixel_ready drops (pixels that owe no result still pass).
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsh_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsh_pkg::DATA_W-1:0]  pwdata,
    output logic [lsh_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  lsh_pkg::pixel_item_t        pixel,
    output logic                        result_valid,
    input  logic                        result_ready,
    output lsh_pkg::result_item_t       result
);

    lsh_pkg::cfg_t      cfg;
    logic               col_valid;
    logic               col_ready;
    lsh_pkg::col_item_t col_item;

    // configuration registers
    lsh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // position counters and line stores
    lsh_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .col_valid   (col_valid),
        .col_ready   (col_ready),
        .col_item    (col_item)
    );

    // window, kernel and output register
    lsh_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .col_valid    (col_valid),
        .col_ready    (col_ready),
        .col_item     (col_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hw/rtl/lsh_regs.sv
// ----------------------------------------------------------------------------
// lsh_regs
// APB-style configuration registers: frame width, frame height and the
// alpha enable. Zero wait states, reads return the stored values.
// ----------------------------------------------------------------------------
module lsh_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsh_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsh_pkg::DATA_W-1:0]  pwdata,
    output logic [lsh_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output lsh_pkg::cfg_t               cfg
);

    lsh_pkg::cfg_t     cfg_reg;
    lsh_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = lsh_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= lsh_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= lsh_pkg::FRAME_HEIGHT_RST;
            cfg_reg.alpha_enable <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lsh_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= pwdata[lsh_pkg::FW_W-1:0];
                lsh_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= pwdata[lsh_pkg::FH_W-1:0];
                lsh_pkg::REG_ALPHA_ENABLE:
                    cfg_reg.alpha_enable <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            lsh_pkg::REG_FRAME_WIDTH:
                prdata = {{(lsh_pkg::DATA_W-lsh_pkg::FW_W){1'b0}}, cfg_reg.frame_width};
            lsh_pkg::REG_FRAME_HEIGHT:
                prdata = {{(lsh_pkg::DATA_W-lsh_pkg::FH_W){1'b0}}, cfg_reg.frame_height};
            lsh_pkg::REG_ALPHA_ENABLE:
                prdata = {{(lsh_pkg::DATA_W-1){1'b0}}, cfg_reg.alpha_enable};
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/lsh_linebuf.sv
// ----------------------------------------------------------------------------
// lsh_linebuf
// Raster position counters and the two line stores. The line stores are
// read when a pixel is accepted and written one stage later, when the
// column item moves on to the window; a same-address write and read in one
// cycle (one-pixel rows) is forwarded.
// ----------------------------------------------------------------------------
module lsh_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsh_pkg::cfg_t         cfg,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  lsh_pkg::pixel_item_t  pixel,
    output logic                  col_valid,
    input  logic                  col_ready,
    output lsh_pkg::col_item_t    col_item
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // line stores
    lsh_pkg::pixel_t upper_mem [MAX_WIDTH];
    lsh_pkg::pixel_t middle_mem [MAX_WIDTH];

    // position of the next pixel
    logic [lsh_pkg::COL_W-1:0] col_count_reg, col_count_next;
    logic [lsh_pkg::ROW_W-1:0] row_count_reg, row_count_next;

    // stage 1
    logic                      s1_valid_reg;
    lsh_pkg::pixel_t           s1_cur_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic [lsh_pkg::ROW_W-1:0] s1_row_reg;
    logic [lsh_pkg::COL_W-1:0] s1_col_reg;
    logic                      s1_row_end_reg;
    logic                      s1_last_row_reg;
    lsh_pkg::pixel_t           up_q_reg, mid_q_reg;
    logic                      fwd_reg;
    lsh_pkg::pixel_t           byp_up_reg, byp_mid_reg;

    logic [lsh_pkg::COL_W-1:0] w_eff;
    logic [lsh_pkg::ROW_W-1:0] h_eff;
    logic [lsh_pkg::COL_W-1:0] cur_col;
    logic [lsh_pkg::ROW_W-1:0] cur_row;
    logic                      row_end, last_row;
    logic [AW-1:0]             rd_addr;
    logic                      in_acc, s1_adv;
    lsh_pkg::pixel_t           in_pix, s1_mdv, s1_upv, s1_mid;

    // effective frame size and clamped position
    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = lsh_pkg::COL_W'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            w_eff = lsh_pkg::COL_W'(MAX_WIDTH);
        else
            w_eff = cfg.frame_width;

        if (cfg.frame_height == '0)
            h_eff = lsh_pkg::ROW_W'(1);
        else
            h_eff = cfg.frame_height;

        cur_col  = (col_count_reg >= w_eff) ? w_eff - 1'b1 : col_count_reg;
        cur_row  = (row_count_reg >= h_eff) ? h_eff - 1'b1 : row_count_reg;
        row_end  = (cur_col == w_eff - 1'b1);
        last_row = (cur_row == h_eff - 1'b1);
    end

    assign rd_addr     = AW'(cur_col);
    assign s1_adv      = s1_valid_reg && col_ready;
    assign pixel_ready = !s1_valid_reg || col_ready;
    assign in_acc      = pixel_valid && pixel_ready;
    assign in_pix      = {pixel.in_alpha, pixel.in_red, pixel.in_green, pixel.in_blue};

    // next position
    always_comb
    begin
        if (row_end)
        begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_count_next = cur_col + 1'b1;
            row_count_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_acc)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // stage 1 payload and forwarding from the write that lands this cycle
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cur_reg      <= in_pix;
            s1_addr_reg     <= rd_addr;
            s1_row_reg      <= cur_row;
            s1_col_reg      <= cur_col;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= last_row;
            fwd_reg         <= s1_valid_reg && (s1_addr_reg == rd_addr);
            byp_up_reg      <= s1_mdv;
            byp_mid_reg     <= s1_cur_reg;
        end
    end

    // line store read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            up_q_reg  <= upper_mem[rd_addr];
            mid_q_reg <= middle_mem[rd_addr];
        end
    end

    // line store write: rows move up by one
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_addr_reg]  <= s1_mdv;
            middle_mem[s1_addr_reg] <= s1_cur_reg;
        end
    end

    // column with replicate padding at the top border
    assign s1_mdv = fwd_reg ? byp_mid_reg : mid_q_reg;
    assign s1_upv = fwd_reg ? byp_up_reg : up_q_reg;
    assign s1_mid = (s1_row_reg != '0) ? s1_mdv : s1_cur_reg;

    assign col_valid         = s1_valid_reg;
    assign col_item.top      = (s1_row_reg >= lsh_pkg::ROW_W'(2)) ? s1_upv : s1_mid;
    assign col_item.mid      = s1_mid;
    assign col_item.cur      = s1_cur_reg;
    assign col_item.row      = s1_row_reg;
    assign col_item.col      = s1_col_reg;
    assign col_item.row_end  = s1_row_end_reg;
    assign col_item.last_row = s1_last_row_reg;

endmodule

FILE: hw/rtl/lsh_window.sv
// ----------------------------------------------------------------------------
// lsh_window
// 3x3 window, the list of results still owed for the latest column, the
// sharpening kernel and the output register. One result leaves per cycle
// while the output is free; a new column enters as the last owed one leaves.
// ----------------------------------------------------------------------------
module lsh_window (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsh_pkg::cfg_t          cfg,
    input  logic                   col_valid,
    output logic                   col_ready,
    input  lsh_pkg::col_item_t     col_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output lsh_pkg::result_item_t  result
);

    // result kinds, also the bit order of the owed-result mask
    typedef enum logic [1:0] {
        KIND_ABOVE_LEFT  = 2'd0,
        KIND_ABOVE_EDGE  = 2'd1,
        KIND_BOTTOM_LEFT = 2'd2,
        KIND_BOTTOM_EDGE = 2'd3
    } kind_t;

    lsh_pkg::pixel_t           win_reg [3][3];
    logic [3:0]                pend_reg, pend_next, pend_clr, pend_new;
    logic [lsh_pkg::ROW_W-1:0] row_reg;
    logic [lsh_pkg::COL_W-1:0] col_reg;
    logic                      out_valid_reg;
    lsh_pkg::result_item_t     out_data_reg, out_data_next;

    logic                      out_free, emit, load;
    kind_t                     kind;
    logic [1:0]                rsel [3];
    logic [1:0]                csel [3];
    lsh_pkg::pixel_t           col_in [3];
    logic [8:0][7:0]           taps [4];
    logic [7:0]                lane_res [4];

    // one channel: 9 * centre minus the eight neighbours, clamped
    function automatic logic [7:0] sharpen(input logic [8:0][7:0] p);
        logic [11:0]       total;
        logic [11:0]       c10;
        logic signed [13:0] v;
        total = '0;
        for (int i = 0; i < 9; i++)
            total = total + 12'(p[i]);
        c10 = {1'b0, p[4], 3'b000} + {3'b000, p[4], 1'b0};
        v = $signed({2'b00, c10}) - $signed({2'b00, total});
        if (v < 0)
            sharpen = 8'd0;
        else if (v > 14'sd255)
            sharpen = 8'd255;
        else
            sharpen = v[7:0];
    endfunction

    // handshake
    assign out_free  = !out_valid_reg || result_ready;
    assign emit      = (pend_reg != '0) && out_free;
    assign pend_clr  = pend_reg & (pend_reg - 1'b1);
    assign col_ready = (pend_reg == '0) || (emit && (pend_clr == '0));
    assign load      = col_valid && col_ready;

    // results owed by the incoming column
    assign pend_new[KIND_ABOVE_LEFT]  = (col_item.row != '0) && (col_item.col != '0);
    assign pend_new[KIND_ABOVE_EDGE]  = (col_item.row != '0) && col_item.row_end;
    assign pend_new[KIND_BOTTOM_LEFT] = col_item.last_row && (col_item.col != '0);
    assign pend_new[KIND_BOTTOM_EDGE] = col_item.last_row && col_item.row_end;

    always_comb
    begin
        if (load)
            pend_next = pend_new;
        else if (emit)
            pend_next = pend_clr;
        else
            pend_next = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // window shift, left border replicated
    assign col_in[0] = col_item.top;
    assign col_in[1] = col_item.mid;
    assign col_in[2] = col_item.cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (load)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (col_item.col == '0)
                begin
                    win_reg[r][0] <= col_in[r];
                    win_reg[r][1] <= col_in[r];
                end
                else
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[r][2] <= col_in[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= col_item.row;
            col_reg <= col_item.col;
        end
    end

    // first owed result
    always_comb
    begin
        if (pend_reg[KIND_ABOVE_LEFT])
            kind = KIND_ABOVE_LEFT;
        else if (pend_reg[KIND_ABOVE_EDGE])
            kind = KIND_ABOVE_EDGE;
        else if (pend_reg[KIND_BOTTOM_LEFT])
            kind = KIND_BOTTOM_LEFT;
        else
            kind = KIND_BOTTOM_EDGE;
    end

    // bottom rows replicate the last row, right edge replicates the last column
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rsel[i] = kind[1] ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
            csel[i] = kind[0] ? ((i == 0) ? 2'd1 : 2'd2) : 2'(i);
        end
        for (int l = 0; l < 4; l++)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    taps[l][i*3+j] = win_reg[rsel[i]][csel[j]][l];
            lane_res[l] = sharpen(taps[l]);
        end
    end

    always_comb
    begin
        out_data_next.out_blue    = lane_res[0];
        out_data_next.out_green   = lane_res[1];
        out_data_next.out_red     = lane_res[2];
        out_data_next.out_alpha   = cfg.alpha_enable ? lane_res[3] : 8'd0;
        out_data_next.out_row     = kind[1] ? row_reg : row_reg - 1'b1;
        out_data_next.out_col     = kind[0] ? col_reg[lsh_pkg::OCOL_W-1:0]
                                            : col_reg[lsh_pkg::OCOL_W-1:0] - 1'b1;
        out_data_next.last_of_run = (pend_clr == '0);
        out_data_next.frame_done  = (kind == KIND_BOTTOM_EDGE);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef NO_ASSERTIONS
    // a column only enters when at most one owed result is left
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ($countones(pend_reg) <= 1))
        else $error("column entered with results still owed");

    // a stalled output freezes the owed results
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != '0 && out_valid_reg && !result_ready) |=> $stable(pend_reg))
        else $error("owed results changed under output stall");

    // the bottom-right pixel always closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_done) |-> out_data_reg.last_of_run)
        else $error("frame_done without last_of_run");
`endif

endmodule

FILE: tb/sv/sharpen_checker.sv
// ----------------------------------------------------------------------------
// sharpen_checker
// Watches the register port and both item channels of the 3x3 sharpening
// filter. Keeps its own copy of the registers, line stores, window and
// position, works out the sharpened results each accepted pixel owes, and
// compares every result item field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module sharpen_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsh_pkg::ADDR_W-1:0]   paddr,
    input  logic [lsh_pkg::DATA_W-1:0]   pwdata,
    input  logic [lsh_pkg::DATA_W-1:0]   prdata,
    input  logic                         pready,
    input  logic                         pixel_valid,
    input  logic                         pixel_ready,
    input  lsh_pkg::pixel_item_t         pixel,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  lsh_pkg::result_item_t        result,
    output int                           errors,
    output int                           pending,
    output int                           results_seen
);

    // Register copies as the host wrote them
    logic [lsh_pkg::FW_W-1:0]  width_reg;
    logic [lsh_pkg::FH_W-1:0]  height_reg;
    logic                      alpha_reg;

    // Line stores, 3x3 window (index row*3 + col) and position of next pixel
    logic [31:0]      upper_line [MAX_WIDTH];
    logic [31:0]      middle_line [MAX_WIDTH];
    logic [8:0][31:0] win;
    int               next_row;
    int               next_col;

    // Sharpened results owed, oldest first
    lsh_pkg::result_item_t sharpened_q [$];

    // One channel of the kernel: 10*centre minus the sum of all nine, clamped
    function automatic logic [7:0] sharpen_lane(input logic [8:0][31:0] px,
                                                input int lane);
        int total;
        int centre;
        int v;
        int i;
        total = 0;
        for (i = 0; i < 9; i++)
            total += int'(px[i][8*lane +: 8]);
        centre = int'(px[4][8*lane +: 8]);
        v = 10 * centre - total;
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // Window tap: with padding the last row/column is repeated
    function automatic int tap(input bit pad, input int i);
        return pad ? ((i == 2) ? 2 : i + 1) : i;
    endfunction

    function automatic lsh_pkg::result_item_t make_result(input bit pad_down,
                                                          input bit pad_right,
                                                          input int row, input int col,
                                                          input bit done);
        logic [8:0][31:0]      px;
        lsh_pkg::result_item_t res;
        int                    i;
        int                    j;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                px[i*3 + j] = win[tap(pad_down, i)*3 + tap(pad_right, j)];
        res.out_blue    = sharpen_lane(px, 0);
        res.out_green   = sharpen_lane(px, 1);
        res.out_red     = sharpen_lane(px, 2);
        res.out_alpha   = alpha_reg ? sharpen_lane(px, 3) : 8'd0;
        res.out_row     = lsh_pkg::ROW_W'(row);
        res.out_col     = lsh_pkg::OCOL_W'(col);
        res.last_of_run = 1'b0;
        res.frame_done  = done;
        return res;
    endfunction

    // Advance the filter state by one pixel and queue the results it owes
    task automatic filter_pixel(input lsh_pkg::pixel_item_t px);
        logic [31:0]           cur;
        logic [31:0]           above;
        logic [31:0]           prior;
        logic [31:0]           top_w;
        logic [31:0]           mid_w;
        logic [2:0][31:0]      fresh;
        lsh_pkg::result_item_t run [4];
        int                    n;
        int                    w;
        int                    h;
        int                    r;
        int                    c;
        int                    k;
        bit                    row_end;
        bit                    last_row;

        // out-of-range sizes and positions past a shrunken frame are clamped
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        r = (next_row >= h) ? h - 1 : next_row;
        c = (next_col >= w) ? w - 1 : next_col;
        row_end  = (c == w - 1);
        last_row = (r == h - 1);

        cur   = {px.in_alpha, px.in_red, px.in_green, px.in_blue};
        above = upper_line[c];
        prior = middle_line[c];
        mid_w = (r >= 1) ? prior : cur;
        top_w = (r >= 2) ? above : mid_w;
        upper_line[c]  = prior;
        middle_line[c] = cur;

        // shift the window; the first column is replicated on the left
        fresh[0] = top_w;
        fresh[1] = mid_w;
        fresh[2] = cur;
        for (k = 0; k < 3; k++)
        begin
            if (c == 0)
            begin
                win[k*3]     = fresh[k];
                win[k*3 + 1] = fresh[k];
            end
            else
            begin
                win[k*3]     = win[k*3 + 1];
                win[k*3 + 1] = win[k*3 + 2];
            end
            win[k*3 + 2] = fresh[k];
        end

        n = 0;
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                run[n] = make_result(1'b0, 1'b0, r - 1, c - 1, 1'b0);
                n++;
            end
            if (row_end)
            begin
                run[n] = make_result(1'b0, 1'b1, r - 1, c, 1'b0);
                n++;
            end
        end
        if (last_row)
        begin
            if (c >= 1)
            begin
                run[n] = make_result(1'b1, 1'b0, r, c - 1, 1'b0);
                n++;
            end
            if (row_end)
            begin
                run[n] = make_result(1'b1, 1'b1, r, c, 1'b1);
                n++;
            end
        end
        if (n > 0)
            run[n-1].last_of_run = 1'b1;
        for (k = 0; k < n; k++)
            sharpened_q.push_back(run[k]);

        if (row_end)
        begin
            next_col = 0;
            next_row = last_row ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input lsh_pkg::result_item_t got);
        lsh_pkg::result_item_t want;
        if (sharpened_q.size() == 0)
        begin
            $error("result at row %0d col %0d with nothing owed", got.out_row, got.out_col);
            errors++;
        end
        else
        begin
            want = sharpened_q.pop_front();
            check_field("out_blue", want.out_blue, got.out_blue);
            check_field("out_green", want.out_green, got.out_green);
            check_field("out_red", want.out_red, got.out_red);
            check_field("out_alpha", want.out_alpha, got.out_alpha);
            check_field("out_row", want.out_row, got.out_row);
            check_field("out_col", want.out_col, got.out_col);
            check_field("last_of_run", want.last_of_run, got.last_of_run);
            check_field("frame_done", want.frame_done, got.frame_done);
        end
    endtask

    function automatic logic [31:0] reg_value(input logic [lsh_pkg::ADDR_W-3:0] idx);
        case (idx)
            lsh_pkg::REG_FRAME_WIDTH:  return 32'(width_reg);
            lsh_pkg::REG_FRAME_HEIGHT: return 32'(height_reg);
            lsh_pkg::REG_ALPHA_ENABLE: return 32'(alpha_reg);
            default:                   return 32'd0;
        endcase
    endfunction

    // Monitor: register access, result check, then pixel prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = lsh_pkg::FRAME_WIDTH_RST;
            height_reg   = lsh_pkg::FRAME_HEIGHT_RST;
            alpha_reg    = 1'b0;
            win          = '0;
            next_row     = 0;
            next_col     = 0;
            errors       = 0;
            results_seen = 0;
            sharpened_q.delete();
            pending      = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[lsh_pkg::ADDR_W-1:2])
                        lsh_pkg::REG_FRAME_WIDTH:
                            width_reg = pwdata[lsh_pkg::FW_W-1:0];
                        lsh_pkg::REG_FRAME_HEIGHT:
                            height_reg = pwdata[lsh_pkg::FH_W-1:0];
                        lsh_pkg::REG_ALPHA_ENABLE:
                            alpha_reg = pwdata[0];
                        default: ;
                    endcase
                end
                else
                begin
                    check_field("prdata", reg_value(paddr[lsh_pkg::ADDR_W-1:2]), prdata);
                end
            end
            if (result_valid && result_ready)
            begin
                check_result(result);
                results_seen++;
            end
            if (pixel_valid && pixel_ready)
                filter_pixel(pixel);
            pending = sharpened_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 3x3 Laplacian sharpening filter. Programs
// frame sizes over the register port, streams pixel frames with random
// gaps and output stalls, and leaves all checking to sharpen_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_WIDTH     = 2048;
    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lsh_pkg::ADDR_W-1:0]    paddr;
    logic [lsh_pkg::DATA_W-1:0]    pwdata;
    logic [lsh_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          pixel_valid;
    logic                          pixel_ready;
    lsh_pkg::pixel_item_t          pixel;
    logic                          result_valid;
    logic                          result_ready;
    lsh_pkg::result_item_t         result;

    int                  check_errors;
    int                  pending;
    int                  results_seen;

    int                  cycles = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic                hold_req;
    bit                  held = 1'b0;
    int                  items_sent = 0;
    int                  frames = 0;

    // Register values as written, and position of the next pixel
    int                  cfg_w = 640;
    int                  cfg_h = 480;
    int                  at_r = 0;
    int                  at_c = 0;

    laplacian_sharpen_3x3 #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    sharpen_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (check_errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results still owed", cycles, pending);
            $display("** laplacian_sharpen_3x3: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Channel value: extremes often, anything else otherwise
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic lsh_pkg::pixel_item_t rand_pixel();
        lsh_pkg::pixel_item_t px;
        px.in_blue  = rand_chan();
        px.in_green = rand_chan();
        px.in_red   = rand_chan();
        px.in_alpha = rand_chan();
        return px;
    endfunction

    // Track where the next pixel lands, with the block's clamping rules
    task automatic step_position();
        int w;
        int h;
        int r;
        int c;
        w = (cfg_w == 0) ? 1 : ((cfg_w > MAX_WIDTH) ? MAX_WIDTH : cfg_w);
        h = (cfg_h == 0) ? 1 : cfg_h;
        r = (at_r >= h) ? h - 1 : at_r;
        c = (at_c >= w) ? w - 1 : at_c;
        if (c == w - 1)
        begin
            at_c = 0;
            if (r == h - 1)
            begin
                at_r = 0;
                frames++;
            end
            else
                at_r = r + 1;
        end
        else
        begin
            at_c = c + 1;
            at_r = r;
        end
    endtask

    task automatic send_pixel(input lsh_pkg::pixel_item_t px);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        items_sent++;
        step_position();
    endtask

    task automatic feed_to_end();
        do
            send_pixel(rand_pixel());
        while (at_r != 0 || at_c != 0);
    endtask

    // Stop offering and wait until every owed result is out
    task automatic drain();
        pixel_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input lsh_pkg::reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsh_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            lsh_pkg::REG_FRAME_WIDTH:  cfg_w = int'(val[lsh_pkg::FW_W-1:0]);
            lsh_pkg::REG_FRAME_HEIGHT: cfg_h = int'(val[lsh_pkg::FH_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic reg_read(input lsh_pkg::reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= lsh_pkg::ADDR_W'(4 * int'(idx));
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input int alpha);
        drain();
        reg_write(lsh_pkg::REG_FRAME_WIDTH, 32'(w));
        reg_write(lsh_pkg::REG_FRAME_HEIGHT, 32'(h));
        reg_write(lsh_pkg::REG_ALPHA_ENABLE, 32'(alpha));
        reg_read(lsh_pkg::REG_FRAME_WIDTH);
        reg_read(lsh_pkg::REG_FRAME_HEIGHT);
        reg_read(lsh_pkg::REG_ALPHA_ENABLE);
    endtask

    // Stimulus
    initial
    begin
        lsh_pkg::pixel_item_t px;
        int                   f_w;
        int                   f_h;
        int                   n;
        int                   i;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        hold_req    <= 1'b0;
        set_idling(30, 69);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-pixel frame: one result, both flags set
        set_frame(1, 1, 1);
        px = '{in_blue: 8'd255, in_green: 8'd0, in_red: 8'd255, in_alpha: 8'd0};
        send_pixel(px);

        // 3x3 checkerboard drives sums to both clamp limits
        set_frame(3, 3, 1);
        for (i = 0; i < 9; i++)
        begin
            px.in_blue  = (i % 2) ? 8'd255 : 8'd0;
            px.in_green = (i % 2) ? 8'd0 : 8'd255;
            px.in_red   = 8'(i * 28);
            px.in_alpha = 8'(255 - i * 28);
            send_pixel(px);
        end

        // Zero width acts as one column; zero height as one row
        set_frame(0, 3, 0);
        feed_to_end();
        set_frame(4, 0, 1);
        feed_to_end();

        // Tallest frame, then cut short mid-frame: row count clamps to last row
        set_frame(2, 65535, 0);
        repeat (6) send_pixel(rand_pixel());
        drain();
        reg_write(lsh_pkg::REG_FRAME_HEIGHT, 32'd2);
        feed_to_end();

        // Random small frames, some resized part way through
        while (items_sent < 130)
        begin
            if (items_sent >= 95)
                set_idling(0, 0);
            else if (items_sent >= 55)
                set_idling(69, 30);
            f_w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            f_h = $urandom_range(1, 5);
            set_frame(f_w, f_h, $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0 && f_w * f_h > 1)
            begin
                n = $urandom_range(1, f_w * f_h - 1);
                repeat (n) send_pixel(rand_pixel());
                drain();
                // only shrink: growing the width would reach unwritten line entries
                if ($urandom_range(0, 1))
                    reg_write(lsh_pkg::REG_FRAME_WIDTH, 32'($urandom_range(0, f_w)));
                if ($urandom_range(0, 1))
                    reg_write(lsh_pkg::REG_FRAME_HEIGHT, 32'($urandom_range(0, f_h)));
                else
                    reg_write(lsh_pkg::REG_ALPHA_ENABLE, 32'($urandom_range(0, 1)));
            end
            feed_to_end();
        end

        // Wider frame with a long output hold-off that fills the block
        set_idling(0, 0);
        set_frame(24, 3, 1);
        hold_req <= 1'b1;
        feed_to_end();

        drain();
        @(negedge clk);
        $display("Covered %0d pixels in %0d frames; %0d sharpened results checked.",
                 items_sent, frames, results_seen);
        $display("Sizes ran from 1x1 to 24x3, incl. zero sizes, mid-frame resizes and a stall.");
        if (check_errors == 0)
            $display("** laplacian_sharpen_3x3: PASSED **");
        else
            $display("** laplacian_sharpen_3x3: FAILED **");
        $finish;
    end

endmodule
